### src/rrq_pkg.sv
package rrq_pkg;

   localparam int ID_W      = 6;
   localparam int MAX_TASKS = 1 << ID_W;
   localparam int OP_W      = 3;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
   localparam logic [OP_W-1:0] OP_YIELD   = 3'd2;
   localparam logic [OP_W-1:0] OP_UNLINK  = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

   localparam logic [ID_W-1:0] IDLE_TASK = '0;

   typedef struct packed {
      logic            rd_en;
      logic [ID_W-1:0] rd_addr;
      logic            nx_we;
      logic [ID_W-1:0] nx_addr;
      logic [ID_W-1:0] nx_data;
      logic            pv_we;
      logic [ID_W-1:0] pv_addr;
      logic [ID_W-1:0] pv_data;
   } link_cmd_type;

   typedef struct packed {
      logic [ID_W-1:0] nx;
      logic [ID_W-1:0] pv;
   } link_rd_type;

endpackage

### src/rrq_links.sv
module rrq_links
   import rrq_pkg::*;
(
   input  logic         clock,
   input  link_cmd_type cmd,
   output link_rd_type  rd
);

   logic [ID_W-1:0] next_link_ff [MAX_TASKS];
   logic [ID_W-1:0] prev_link_ff [MAX_TASKS];
   logic [ID_W-1:0] nx_rd_ff;
   logic [ID_W-1:0] pv_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.nx_we) begin
         next_link_ff[cmd.nx_addr] <= cmd.nx_data;
      end
      if (cmd.rd_en) begin
         nx_rd_ff <= next_link_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pv_we) begin
         prev_link_ff[cmd.pv_addr] <= cmd.pv_data;
      end
      if (cmd.rd_en) begin
         pv_rd_ff <= prev_link_ff[cmd.rd_addr];
      end
   end

   assign rd.nx = nx_rd_ff;
   assign rd.pv = pv_rd_ff;

endmodule

### src/rrq_seq.sv
module rrq_seq
   import rrq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [OP_W-1:0] req_type,
   input  logic [ID_W-1:0] req_task_id,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [ID_W-1:0] rsp_current_task,
   output logic            rsp_switch_needed,
   output logic [ID_W-1:0] rsp_removed_task,
   output logic            rsp_error,
   output link_cmd_type    cmd,
   input  link_rd_type     rd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                 state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [ID_W-1:0]      tgt_ff, tgt_in;
   logic [ID_W-1:0]      head_ff, head_in;
   logic [ID_W-1:0]      tail_ff, tail_in;
   logic                 empty_ff, empty_in;
   logic [MAX_TASKS-1:0] queued_ff, queued_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_cur_ff, rsp_cur_in;
   logic                 rsp_sw_ff, rsp_sw_in;
   logic [ID_W-1:0]      rsp_rem_ff, rsp_rem_in;
   logic                 rsp_err_ff, rsp_err_in;

   logic accept, slot_free;
   logic det_en, app_en, yield_mv, err;
   logic [ID_W-1:0] removed;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      det_en   = 1'b0;
      app_en   = 1'b0;
      yield_mv = 1'b0;
      err      = 1'b0;
      removed  = IDLE_TASK;
      case (op_ff)
         OP_ENQUEUE: begin
            if (queued_ff[tgt_ff]) begin
               err = 1'b1;
            end else begin
               app_en = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!queued_ff[tgt_ff]) begin
               err = 1'b1;
            end else begin
               det_en = 1'b1;
            end
         end
         OP_YIELD: begin
            yield_mv = !empty_ff && (head_ff != IDLE_TASK) && (head_ff != tail_ff);
         end
         OP_UNLINK: begin
            if (empty_ff) begin
               err = 1'b1;
            end else begin
               removed = head_ff;
               det_en  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tgt_in       = tgt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      empty_in     = empty_ff;
      queued_in    = queued_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cur_in   = rsp_cur_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_err_in   = rsp_err_ff;
      cmd          = '0;

      cmd.rd_en   = accept;
      cmd.rd_addr = (req_type == OP_YIELD || req_type == OP_UNLINK) ? head_ff : req_task_id;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_type;
               tgt_in   = cmd.rd_addr;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               if (det_en) begin
                  queued_in[tgt_ff] = 1'b0;
                  if (head_ff == tgt_ff && tail_ff == tgt_ff) begin
                     empty_in = 1'b1;
                     head_in  = IDLE_TASK;
                     tail_in  = IDLE_TASK;
                  end else if (head_ff == tgt_ff) begin
                     head_in = rd.nx;
                  end else if (tail_ff == tgt_ff) begin
                     tail_in = rd.pv;
                  end else begin
                     cmd.nx_we   = 1'b1;
                     cmd.nx_addr = rd.pv;
                     cmd.nx_data = rd.nx;
                     cmd.pv_we   = 1'b1;
                     cmd.pv_addr = rd.nx;
                     cmd.pv_data = rd.pv;
                  end
               end
               if (app_en) begin
                  queued_in[tgt_ff] = 1'b1;
                  if (empty_ff) begin
                     head_in  = tgt_ff;
                     tail_in  = tgt_ff;
                     empty_in = 1'b0;
                  end else begin
                     cmd.nx_we   = 1'b1;
                     cmd.nx_addr = tail_ff;
                     cmd.nx_data = tgt_ff;
                     cmd.pv_we   = 1'b1;
                     cmd.pv_addr = tgt_ff;
                     cmd.pv_data = tail_ff;
                     tail_in     = tgt_ff;
                  end
               end
               if (yield_mv) begin
                  head_in     = rd.nx;
                  cmd.nx_we   = 1'b1;
                  cmd.nx_addr = tail_ff;
                  cmd.nx_data = head_ff;
                  cmd.pv_we   = 1'b1;
                  cmd.pv_addr = head_ff;
                  cmd.pv_data = tail_ff;
                  tail_in     = head_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_cur_in   = empty_in ? IDLE_TASK : head_in;
               rsp_sw_in    = yield_mv;
               rsp_rem_in   = removed;
               rsp_err_in   = err;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= IDLE_TASK;
         tail_ff      <= IDLE_TASK;
         empty_ff     <= 1'b1;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      tgt_ff     <= tgt_in;
      rsp_cur_ff <= rsp_cur_in;
      rsp_sw_ff  <= rsp_sw_in;
      rsp_rem_ff <= rsp_rem_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_task  = rsp_cur_ff;
   assign rsp_switch_needed = rsp_sw_ff;
   assign rsp_removed_task  = rsp_rem_ff;
   assign rsp_error         = rsp_err_ff;

   a_empty_clear: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == IDLE_TASK && tail_ff == IDLE_TASK))
      else $error("empty queue with non-zero head or tail");

   a_empty_flags: assert property (@(posedge clock) disable iff (reset)
      empty_ff == (queued_ff == '0))
      else $error("empty flag disagrees with membership flags");

   a_ends_queued: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (queued_ff[head_ff] && queued_ff[tail_ff]))
      else $error("head or tail not marked queued");

   a_word_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result word raised outside execute step");

endmodule

### src/round_robin_run_queue.sv
// channel | ports                                       | direction
// --------+---------------------------------------------+----------
// req     | req_valid req_ready req_type req_task_id    | in
// rsp     | rsp_valid rsp_ready rsp_current_task        | out
//         | rsp_switch_needed rsp_removed_task rsp_error|
//
// On accept a word reads both link memories at the target task; the execute
// step then updates the links, head and tail and loads the result register.
// A new word is taken while the previous result still waits; the execute step
// holds only while that result register is occupied and rsp_ready is low.
// Reset clears the membership flags and the head, tail and empty state at
// once; the link memories need no clearing.
module round_robin_run_queue
   import rrq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [OP_W-1:0] req_type,
   input  logic [ID_W-1:0] req_task_id,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [ID_W-1:0] rsp_current_task,
   output logic            rsp_switch_needed,
   output logic [ID_W-1:0] rsp_removed_task,
   output logic            rsp_error
);

   link_cmd_type cmd;
   link_rd_type  rd;

   rrq_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_task_id       (req_task_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_current_task  (rsp_current_task),
      .rsp_switch_needed (rsp_switch_needed),
      .rsp_removed_task  (rsp_removed_task),
      .rsp_error         (rsp_error),
      .cmd               (cmd),
      .rd                (rd)
   );

   rrq_links u_links (
      .clock (clock),
      .cmd   (cmd),
      .rd    (rd)
   );

endmodule

### tb/round_robin_run_queue_tb.sv
`timescale 1ns / 100ps

module round_robin_run_queue_tb;
   import rrq_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int STALL_LIMIT   = 1000;
   localparam int RANDOM_WORDS  = 500;
   localparam int DRAIN_CYCLES  = 10;

   class run_queue_scoreboard;
      typedef struct packed {
         logic [ID_W-1:0] current_task;
         logic            switch_needed;
         logic [ID_W-1:0] removed_task;
         logic            error;
      } sched_word_type;

      bit              in_queue  [MAX_TASKS];
      bit [ID_W-1:0]   next_task [MAX_TASKS];
      bit [ID_W-1:0]   prev_task [MAX_TASKS];
      bit [ID_W-1:0]   head;
      bit [ID_W-1:0]   tail;
      bit              empty = 1'b1;
      sched_word_type  expected [$];
      int              mismatches;

      function bit [ID_W-1:0] running();
         return empty ? IDLE_TASK : head;
      endfunction

      function void enqueue_tail(bit [ID_W-1:0] t);
         if (empty) begin
            head  = t;
            tail  = t;
            empty = 1'b0;
         end else begin
            next_task[tail] = t;
            prev_task[t]    = tail;
            tail            = t;
         end
         in_queue[t] = 1'b1;
      endfunction

      function void unlink_task(bit [ID_W-1:0] t);
         bit [ID_W-1:0] p;
         bit [ID_W-1:0] n;
         p = prev_task[t];
         n = next_task[t];
         if (head == t && tail == t) begin
            empty = 1'b1;
            head  = IDLE_TASK;
            tail  = IDLE_TASK;
         end else if (head == t) begin
            head = n;
         end else if (tail == t) begin
            tail = p;
         end else begin
            next_task[p] = n;
            prev_task[n] = p;
         end
         in_queue[t] = 1'b0;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] tid);
         sched_word_type w;
         bit [ID_W-1:0]  self;
         w = '0;
         case (op)
            OP_ENQUEUE: begin
               if (in_queue[tid]) w.error = 1'b1;
               else enqueue_tail(tid);
            end
            OP_REMOVE: begin
               if (!in_queue[tid]) w.error = 1'b1;
               else unlink_task(tid);
            end
            OP_YIELD: begin
               self = running();
               if (!empty && self != IDLE_TASK) begin
                  unlink_task(self);
                  enqueue_tail(self);
               end
               w.switch_needed = (running() != self);
            end
            OP_UNLINK: begin
               if (empty) begin
                  w.error = 1'b1;
               end else begin
                  w.removed_task = head;
                  unlink_task(head);
               end
            end
            default: ;
         endcase
         w.current_task = running();
         expected.push_back(w);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_result(sched_word_type got);
         sched_word_type want;
         if (expected.size() == 0) begin
            report($sformatf("word with none pending, current_task %0d", got.current_task));
            return;
         end
         want = expected.pop_front();
         if (got.current_task !== want.current_task)
            report($sformatf("current_task %0d, want %0d", got.current_task,
                             want.current_task));
         if (got.switch_needed !== want.switch_needed)
            report($sformatf("switch_needed %b, want %b", got.switch_needed,
                             want.switch_needed));
         if (got.removed_task !== want.removed_task)
            report($sformatf("removed_task %0d, want %0d", got.removed_task,
                             want.removed_task));
         if (got.error !== want.error)
            report($sformatf("error %b, want %b", got.error, want.error));
      endtask

      function int pending();
         return expected.size();
      endfunction

      function int depth();
         int count;
         count = 0;
         foreach (in_queue[i]) if (in_queue[i]) count++;
         return count;
      endfunction

      function logic [ID_W-1:0] pick_task(bit queued);
         int ids [$];
         foreach (in_queue[i]) if (in_queue[i] == queued) ids.push_back(i);
         if (ids.size() == 0) return ID_W'($urandom_range(0, MAX_TASKS - 1));
         return ID_W'(ids[$urandom_range(0, ids.size() - 1)]);
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic [OP_W-1:0] req_type;
   logic [ID_W-1:0] req_task_id;
   logic            rsp_valid;
   logic            rsp_ready;
   logic [ID_W-1:0] rsp_current_task;
   logic            rsp_switch_needed;
   logic [ID_W-1:0] rsp_removed_task;
   logic            rsp_error;

   bit                  idling = 1'b1;
   int                  quiet_cycles;
   run_queue_scoreboard sb = new();

   round_robin_run_queue DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_task_id       (req_task_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_current_task  (rsp_current_task),
      .rsp_switch_needed (rsp_switch_needed),
      .rsp_removed_task  (rsp_removed_task),
      .rsp_error         (rsp_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] tid);
      int gap;
      gap = idling ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= op;
      req_task_id <= tid;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, tid);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic send_random();
      int            r;
      int            enq_weight;
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] tid;
      enq_weight = (sb.depth() < 3) ? 55 : (sb.depth() > 24) ? 15 : 33;
      r   = $urandom_range(0, 99);
      tid = ID_W'($urandom_range(0, MAX_TASKS - 1));
      if (r < enq_weight) begin
         op = OP_ENQUEUE;
         if ($urandom_range(0, 9) != 0) tid = sb.pick_task(1'b0);
      end else if (r < enq_weight + 20) begin
         op = OP_REMOVE;
         if ($urandom_range(0, 9) != 0) tid = sb.pick_task(1'b1);
      end else if (r < enq_weight + 45) begin
         op = OP_YIELD;
      end else if (r < enq_weight + 57) begin
         op = OP_UNLINK;
      end else if (r < enq_weight + 64) begin
         op = OP_QUERY;
      end else begin
         op = OP_SPARE_FIRST + OP_W'($urandom_range(0, OP_SPARE_LAST - OP_SPARE_FIRST));
      end
      send_request(op, tid);
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = idling ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result({rsp_current_task, rsp_switch_needed, rsp_removed_task, rsp_error});
         @(negedge clock);
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_type    = OP_QUERY;
      req_task_id = IDLE_TASK;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      send_request(OP_QUERY, 6'd0);
      send_request(OP_UNLINK, 6'd0);
      send_request(OP_YIELD, 6'd0);
      send_request(OP_REMOVE, 6'd63);
      send_request(OP_ENQUEUE, IDLE_TASK);
      send_request(OP_YIELD, 6'd63);
      send_request(OP_ENQUEUE, 6'd63);
      send_request(OP_ENQUEUE, 6'd63);
      send_request(OP_ENQUEUE, 6'd42);
      send_request(OP_ENQUEUE, 6'd21);
      send_request(OP_YIELD, 6'd0);
      send_request(OP_REMOVE, IDLE_TASK);
      send_request(OP_YIELD, 6'd0);
      send_request(OP_REMOVE, 6'd21);
      send_request(OP_REMOVE, 6'd63);
      send_request(OP_ENQUEUE, 6'd1);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         send_request(OP_W'(op), 6'd63);
      send_request(OP_UNLINK, 6'd0);
      send_request(OP_UNLINK, 6'd0);
      send_request(OP_ENQUEUE, 6'd7);
      send_request(OP_YIELD, 6'd0);
      send_request(OP_UNLINK, 6'd0);
      hold_until_drained();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 40 == 0) idling = ($urandom_range(0, 3) != 0);
         if (i == RANDOM_WORDS / 2) hold_until_drained();
         send_random();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### files.f
src/rrq_pkg.sv
src/rrq_links.sv
src/rrq_seq.sv
src/round_robin_run_queue.sv
tb/round_robin_run_queue_tb.sv
